// ----- rtl/core/pwc_pkg.sv -----
// Package for the multi-channel pulse width capture block.
// Holds widths, register codes and the job and result types shared by the core modules.
// No dependencies.
package pwc_pkg;

    localparam int CNT_W   = 16;   // timer count and pulse width
    localparam int CH_W    = 2;    // channel field
    localparam int CHANNELS = 4;   // channels in use
    localparam int CH_MAX  = 8;    // largest supported channel count
    localparam int TMO_W   = 2;    // timeout register
    localparam int QDEPTH  = 4;    // front-to-back job queue
    localparam int QPTR_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TMO_W-1:0] TMO_RESET = 2'd2;
    localparam logic [TMO_W-1:0] OVF_SAT   = 2'd3;

    // register index as seen on paddr[2]
    localparam logic REG_IDX_TIMEOUT = 1'b0;

    // input kinds
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_CAPTURE = 1'b1;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic              tick;
        logic [CH_MAX-1:0] tmo_mask;
        logic [CH_W-1:0]   channel;
        logic [CNT_W-1:0]  width;
        logic              complete;
        logic              watch_falling;
    } job_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [CNT_W-1:0] pulse_width;
        logic             complete;
        logic             timed_out;
        logic             watch_falling;
        logic             last;
    } result_t;

endpackage

// ----- rtl/core/multi_channel_pulse_width_capture.sv -----
// Top level of the multi-channel pulse width capture block.
// Depends on pwc_pkg, pwc_front, pwc_queue and pwc_back.
//
// Usage:
//   Slave stream: one beat per event. s_tuser = 0 is a timer overflow tick,
//   1 a capture event on the channel in s_tdata with the latched count.
//   Master stream: result beats. A capture gives one beat (pulse start with
//   watch_falling set, or a finished width). A tick gives one beat per
//   channel that timed out, lowest channel first, m_tlast on the final one,
//   and no beat when nothing timed out. Captures on channels at or above
//   CHANNELS are dropped.
//   APB port: register 0 at address 0 is the timeout in overflows (reset 2).
//   The first result beat passes through the job queue and then the output register.
//   Throughput: one input beat per cycle while the queue is not full, one result
//   beat per cycle while the receiver is ready; a tick timing out N channels gives N beats.
//   The four-entry job queue lets input continue while the receiver stalls;
//   s_tready drops only when the queue is full.
//   Reset disarms all channels and clears the queue and the output valid flag.
module multi_channel_pulse_width_capture (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] channel, [17:2] capture_value, rest zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] out_channel, [17:2] pulse_width, rest zero
    output logic [2:0]  m_tuser,   // [0] complete, [1] timed_out, [2] watch_falling
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [pwc_pkg::ADDR_W-1:0] paddr,
    input  logic [pwc_pkg::DATA_W-1:0] pwdata,
    output logic [pwc_pkg::DATA_W-1:0] prdata,
    output logic        pready
);
    import pwc_pkg::*;

    logic [TMO_W-1:0] timeout_reg;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    job_t             job_in;
    job_t             job_head;
    result_t          result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_TIMEOUT) ? DATA_W'(timeout_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TMO_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_TIMEOUT)
            timeout_reg <= pwdata[TMO_W-1:0];
    end

    pwc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .req_type      (s_tuser[0]),
        .channel       (s_tdata[1:0]),
        .capture_value (s_tdata[17:2]),
        .timeout       (timeout_reg),
        .q_full        (q_full),
        .push          (push),
        .job           (job_in)
    );

    pwc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .pop   (pop),
        .dout  (job_head),
        .empty (q_empty),
        .full  (q_full)
    );

    pwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (job_head),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .result    (result)
    );

    assign m_tdata = {6'b0, result.pulse_width, result.out_channel};
    assign m_tuser = {result.watch_falling, result.timed_out, result.complete};
    assign m_tlast = result.last;

endmodule

// ----- rtl/core/pwc_front.sv -----
// Front end: accepts input beats, keeps per-channel arm state and builds jobs.
// Depends on pwc_pkg.
module pwc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [pwc_pkg::CH_W-1:0]   channel,
    input  logic [pwc_pkg::CNT_W-1:0]  capture_value,
    input  logic [pwc_pkg::TMO_W-1:0]  timeout,
    input  logic                       q_full,
    output logic                       push,
    output pwc_pkg::job_t              job
);
    import pwc_pkg::*;

    logic                 armed_reg  [CHANNELS];
    logic                 armed_next [CHANNELS];
    logic [TMO_W-1:0]     ovf_reg    [CHANNELS];
    logic [TMO_W-1:0]     ovf_next   [CHANNELS];
    logic [CNT_W-1:0]     stamp_reg  [CHANNELS];
    logic [CHANNELS-1:0]  tmo_mask;
    logic                 sel_armed;
    logic [CNT_W-1:0]     sel_stamp;
    logic                 ch_ok;
    logic                 accept;
    logic [TMO_W-1:0]     ovf_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign ch_ok    = int'(channel) < CHANNELS;

    always_comb
    begin
        sel_armed = 1'b0;
        sel_stamp = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (int'(channel) == c)
            begin
                sel_armed = armed_reg[c];
                sel_stamp = stamp_reg[c];
            end
        end
    end

    always_comb
    begin
        tmo_mask = '0;
        ovf_inc  = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            armed_next[c] = armed_reg[c];
            ovf_next[c]   = ovf_reg[c];
            if (accept && req_type == REQ_TICK && armed_reg[c])
            begin
                ovf_inc = (ovf_reg[c] == OVF_SAT) ? OVF_SAT : ovf_reg[c] + 1'b1;
                if (ovf_inc >= timeout)
                begin
                    tmo_mask[c]   = 1'b1;
                    armed_next[c] = 1'b0;
                    ovf_next[c]   = '0;
                end
                else
                begin
                    ovf_next[c] = ovf_inc;
                end
            end
            else if (accept && req_type == REQ_CAPTURE && int'(channel) == c)
            begin
                armed_next[c] = !armed_reg[c];
                ovf_next[c]   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                armed_reg[c] <= 1'b0;
                ovf_reg[c]   <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                armed_reg[c] <= armed_next[c];
                ovf_reg[c]   <= ovf_next[c];
            end
        end
    end

    // start stamp is read only while armed, so it needs no reset
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (accept && req_type == REQ_CAPTURE && int'(channel) == c && !armed_reg[c])
                stamp_reg[c] <= capture_value;
        end
    end

    always_comb
    begin
        job               = '0;
        job.tick          = (req_type == REQ_TICK);
        job.tmo_mask      = CH_MAX'(tmo_mask);
        job.channel       = channel;
        // modular difference covers the counter wrap
        job.width         = sel_armed ? capture_value - sel_stamp : '0;
        job.complete      = sel_armed;
        job.watch_falling = !sel_armed;
        if (req_type == REQ_TICK)
            push = accept && (|tmo_mask);
        else
            push = accept && ch_ok;
    end

endmodule

// ----- rtl/core/pwc_queue.sv -----
// Short job queue between the front and the back.
// Depends on pwc_pkg.
module pwc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pwc_pkg::job_t din,
    input  logic          pop,
    output pwc_pkg::job_t dout,
    output logic          empty,
    output logic          full
);
    import pwc_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ----- rtl/core/pwc_back.sv -----
// Back end: expands queued jobs into registered result beats, one per cycle unless stalled.
// Depends on pwc_pkg.
module pwc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  pwc_pkg::job_t    head,
    output logic             pop,
    input  logic             out_ready,
    output logic             out_valid,
    output pwc_pkg::result_t result
);
    import pwc_pkg::*;

    logic [CH_MAX-1:0] done_reg;
    logic [CH_MAX-1:0] rem;
    logic [CH_MAX-1:0] sel_oh;
    logic [CH_MAX-1:0] rest;
    logic [2:0]        sel_idx;
    logic              load;
    logic              valid_reg;
    result_t           res_reg;
    result_t           res_next;

    assign rem    = head.tmo_mask & ~done_reg;
    assign sel_oh = rem & (~rem + 1'b1);
    assign rest   = rem & ~sel_oh;
    assign load   = !q_empty && (!valid_reg || out_ready);
    assign pop    = load && (!head.tick || rest == '0);

    always_comb
    begin
        sel_idx = '0;
        for (int c = CH_MAX - 1; c >= 0; c--)
        begin
            if (rem[c])
                sel_idx = 3'(c);
        end
    end

    always_comb
    begin
        if (head.tick)
        begin
            res_next.out_channel   = sel_idx[CH_W-1:0];
            res_next.pulse_width   = '0;
            res_next.complete      = 1'b1;
            res_next.timed_out     = 1'b1;
            res_next.watch_falling = 1'b0;
            res_next.last          = (rest == '0);
        end
        else
        begin
            res_next.out_channel   = head.channel;
            res_next.pulse_width   = head.width;
            res_next.complete      = head.complete;
            res_next.timed_out     = 1'b0;
            res_next.watch_falling = head.watch_falling;
            res_next.last          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            // track channels already reported for the head tick
            if (pop)
                done_reg <= '0;
            else if (load)
                done_reg <= done_reg | sel_oh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;

endmodule

// ----- rtl/core/pwc_checker.sv -----
// Port-level checker for the pulse width capture block, bound to the top level.
// Depends on the port list of multi_channel_pulse_width_capture.
module pwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // hold a stalled beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a timeout is a completion with zero width that rearms for a rising edge
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && !m_tuser[2] && m_tdata[17:2] == 16'd0)
        else $error("bad timeout result");

    // a pulse start has zero width, asks for a falling edge and ends its item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tuser[2] && m_tlast && m_tdata[17:2] == 16'd0)
        else $error("bad pulse start result");

    // only timeout beats may be followed by more beats of the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser[1])
        else $error("non-final beat that is not a timeout");

endmodule

bind multi_channel_pulse_width_capture pwc_checker u_pwc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
